>>> hw/rtl/pcl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcl_pkg: shared types and constants of the PI current loop
// Register map, sequencer states, multiplier widths and fixed-point limits.
// ----------------------------------------------------------------------------
package pcl_pkg;

  localparam int unsigned AddrW = 4;
  localparam int unsigned DataW = 32;

  localparam logic [1:0] RegPropGain  = 2'd0;
  localparam logic [1:0] RegIntegGain = 2'd1;
  localparam logic [1:0] RegPwmPeriod = 2'd2;

  localparam logic [15:0] PropGainRst  = 16'd1311;
  localparam logic [15:0] IntegGainRst = 16'd1180;
  localparam logic [15:0] PwmPeriodRst = 16'd50000;

  localparam int unsigned MulAW = 33;
  localparam int unsigned MulBW = 19;
  localparam int unsigned MulPW = MulAW + MulBW;

  // floor(2^24 / 100); the quotient estimate is low by at most one.
  localparam logic [MulBW-1:0] RecipDiv100 = 19'd167772;
  localparam logic [MulBW-1:0] Hundred     = 19'd100;

  typedef struct packed {
    logic [15:0] prop_gain;
    logic [15:0] integ_gain;
    logic [15:0] pwm_period;
  } cfg_t;

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_ACC   = 8'b0000_0010,
    ST_IMUL  = 8'b0000_0100,
    ST_PMUL  = 8'b0000_1000,
    ST_SUM   = 8'b0001_0000,
    ST_PWMUL = 8'b0010_0000,
    ST_QMUL  = 8'b0100_0000,
    ST_RMUL  = 8'b1000_0000
  } state_e;

endpackage

>>> hw/rtl/pcl_apb_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcl_apb_regs: configuration register file
// Holds the two loop gains and the PWM period behind an APB-style port.
// ----------------------------------------------------------------------------
module pcl_apb_regs (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [pcl_pkg::AddrW-1:0]  paddr,
  input  logic [pcl_pkg::DataW-1:0]  pwdata,
  output logic [pcl_pkg::DataW-1:0]  prdata,
  output logic                       pready,
  output pcl_pkg::cfg_t              cfg_o
);
  import pcl_pkg::*;

  cfg_t cfg_q;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.prop_gain  <= PropGainRst;
      cfg_q.integ_gain <= IntegGainRst;
      cfg_q.pwm_period <= PwmPeriodRst;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        RegPropGain:  cfg_q.prop_gain  <= pwdata[15:0];
        RegIntegGain: cfg_q.integ_gain <= pwdata[15:0];
        RegPwmPeriod: cfg_q.pwm_period <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      RegPropGain:  prdata = {16'd0, cfg_q.prop_gain};
      RegIntegGain: prdata = {16'd0, cfg_q.integ_gain};
      RegPwmPeriod: prdata = {16'd0, cfg_q.pwm_period};
      default:      prdata = '0;
    endcase
  end

endmodule

>>> hw/rtl/pcl_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcl_mul: shared signed multiplier
// One signed product per cycle for the multiply steps of the control update.
// ----------------------------------------------------------------------------
module pcl_mul (
  input  logic signed [pcl_pkg::MulAW-1:0] a_i,
  input  logic signed [pcl_pkg::MulBW-1:0] b_i,
  output logic signed [pcl_pkg::MulPW-1:0] p_o
);
  import pcl_pkg::*;

  assign p_o = MulPW'(a_i) * MulPW'(b_i);

endmodule

>>> hw/rtl/pcl_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcl_seq: control update sequencer and datapath
// Steps one tick through the shared multiplier and holds the integral state.
// ----------------------------------------------------------------------------
module pcl_seq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pcl_pkg::cfg_t       cfg_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic signed [15:0]  ref_current_ma_i,
  input  logic signed [15:0]  meas_current_ma_i,
  input  logic signed [15:0]  feedforward_i,
  input  logic                profile_positive_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [15:0]         pulse_width_o,
  output logic                drive_forward_o
);
  import pcl_pkg::*;

  localparam logic signed [MulPW-1:0] IntLimPos = 52'sd655360;
  localparam logic signed [MulPW-1:0] IntLimNeg = -52'sd655360;
  localparam logic signed [26:0]      FullPos   = 27'sd25600;
  localparam logic signed [26:0]      FullNeg   = -27'sd25600;

  state_e state_q, state_d;

  logic signed [31:0] acc_q;
  logic signed [16:0] err_q;
  logic signed [16:0] ff_q;
  logic               dir_q;
  logic signed [12:0] iterm_q;
  logic signed [25:0] pterm_q;
  logic [14:0]        mag_q;
  logic [22:0]        y_q;
  logic [15:0]        q_q;
  logic               out_valid_q;
  logic [15:0]        pw_q;
  logic               fwd_q;

  logic signed [MulAW-1:0] mul_a;
  logic signed [MulBW-1:0] mul_b;
  logic signed [MulPW-1:0] mul_p;

  logic signed [32:0] acc_sum;
  logic signed [26:0] u_sum;
  logic signed [26:0] u_clamp;
  logic [23:0]        rem;
  logic               load_out;

  pcl_mul u_mul (
    .a_i (mul_a),
    .b_i (mul_b),
    .p_o (mul_p)
  );

  assign in_ready_o      = (state_q == ST_IDLE);
  assign out_valid_o     = out_valid_q;
  assign pulse_width_o   = pw_q;
  assign drive_forward_o = fwd_q;

  assign acc_sum  = 33'(acc_q) + 33'(err_q);
  assign u_sum    = 27'(pterm_q) + 27'(iterm_q) + 27'(ff_q);
  assign rem      = {1'b0, y_q} - mul_p[23:0];
  assign load_out = (state_q == ST_RMUL) && (!out_valid_q || out_ready_i);

  always_comb begin
    if (u_sum > FullPos) begin
      u_clamp = FullPos;
    end else if (u_sum < FullNeg) begin
      u_clamp = FullNeg;
    end else begin
      u_clamp = u_sum;
    end
  end

  always_comb begin
    unique case (state_q)
      ST_IMUL: begin
        mul_a = {acc_q[31], acc_q};
        mul_b = {3'b000, cfg_i.integ_gain};
      end
      ST_PMUL: begin
        mul_a = 33'(err_q);
        mul_b = {3'b000, cfg_i.prop_gain};
      end
      ST_PWMUL: begin
        mul_a = {18'd0, mag_q};
        mul_b = {3'b000, cfg_i.pwm_period};
      end
      ST_QMUL: begin
        mul_a = {10'd0, y_q};
        mul_b = RecipDiv100;
      end
      ST_RMUL: begin
        mul_a = {17'd0, q_q};
        mul_b = Hundred;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_valid_i) state_d = ST_ACC;
      ST_ACC:   state_d = ST_IMUL;
      ST_IMUL:  state_d = ST_PMUL;
      ST_PMUL:  state_d = ST_SUM;
      ST_SUM:   state_d = ST_PWMUL;
      ST_PWMUL: state_d = ST_QMUL;
      ST_QMUL:  state_d = ST_RMUL;
      ST_RMUL:  if (load_out) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      acc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_ACC) begin
        if (acc_sum[32] != acc_sum[31]) begin
          acc_q <= acc_sum[32] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
        end else begin
          acc_q <= acc_sum[31:0];
        end
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          err_q <= 17'(ref_current_ma_i) - 17'(meas_current_ma_i);
          ff_q  <= profile_positive_i ? 17'(feedforward_i) : -17'(feedforward_i);
          dir_q <= profile_positive_i;
        end
      end
      ST_IMUL: begin
        if (mul_p > IntLimPos) begin
          iterm_q <= 13'sd2560;
        end else if (mul_p < IntLimNeg) begin
          iterm_q <= -13'sd2560;
        end else begin
          iterm_q <= mul_p[20:8];
        end
      end
      ST_PMUL:  pterm_q <= mul_p[33:8];
      ST_SUM:   mag_q <= u_clamp[26] ? 15'(-u_clamp) : 15'(u_clamp);
      ST_PWMUL: y_q <= mul_p[30:8];
      ST_QMUL:  q_q <= mul_p[39:24];
      ST_RMUL: begin
        if (load_out) begin
          pw_q  <= (rem >= 24'd100) ? q_q + 16'd1 : q_q;
          fwd_q <= dir_q;
        end
      end
      default: ;
    endcase
  end

endmodule

>>> hw/rtl/pi_current_loop_pwm_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pi_current_loop_pwm_core: PI current loop with PWM output
// Top level: configuration registers, update sequencer and shared multiplier.
// ----------------------------------------------------------------------------
// Each input beat carries the commanded and measured current in mA, a Q8
// percent feedforward term and the sign of the acceleration profile. Each
// beat produces one output beat holding the PWM high time in timer ticks and
// the drive direction. Both channels use a valid/ready handshake.
// An accepted beat is worked through seven steps on a single 33 by 19 bit
// multiplier, which is used five times per update; the result is registered
// in the last step, and the next beat is taken only after the update ends.
// Input ready is high only while the sequencer is idle. The result sits in
// an output register, so the next beat may be accepted while it waits; if
// the receiver stalls, the following update holds in its last step until
// the output register is free.
// Reset clears the integral accumulator and restores the register defaults:
// proportional gain 1311, integral gain 1180 and period 50000 ticks.
// Registers sit at byte addresses 0, 4 and 8; pready is always high.
// ----------------------------------------------------------------------------
module pi_current_loop_pwm_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [pcl_pkg::AddrW-1:0]  paddr,
  input  logic [pcl_pkg::DataW-1:0]  pwdata,
  output logic [pcl_pkg::DataW-1:0]  prdata,
  output logic                       pready,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic signed [15:0]         ref_current_ma_i,
  input  logic signed [15:0]         meas_current_ma_i,
  input  logic signed [15:0]         feedforward_i,
  input  logic                       profile_positive_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [15:0]                pulse_width_o,
  output logic                       drive_forward_o
);
  import pcl_pkg::*;

  cfg_t cfg;

  pcl_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  pcl_seq u_seq (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_i              (cfg),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .ref_current_ma_i   (ref_current_ma_i),
    .meas_current_ma_i  (meas_current_ma_i),
    .feedforward_i      (feedforward_i),
    .profile_positive_i (profile_positive_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .pulse_width_o      (pulse_width_o),
    .drive_forward_o    (drive_forward_o)
  );

endmodule
